FILE: design/seven_segment_char_shifter_assert.svh
// Assertion macros for the seven-segment character shifter.
`ifndef SEVEN_SEGMENT_CHAR_SHIFTER_ASSERT_SVH
`define SEVEN_SEGMENT_CHAR_SHIFTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SSCS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sscs check failed");

// Next-cycle implication, checked outside reset.
`define SSCS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sscs check failed");

`endif

FILE: design/sscs_pkg.sv
// Shared types, constants and the character-to-segment table of the shifter.
package sscs_pkg;

	// Kind of an output beat.
	typedef enum logic [1:0] {
		KIND_BEGIN = 2'd0,
		KIND_PORT  = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_FRAME,
		SEQ_END
	} seq_state_t;

	localparam int CHAR_W = 8;
	localparam int PAT_W = 8;
	localparam logic [1:0] PHASE_HIGH = 2'd1;
	localparam logic [1:0] PHASE_LAST = 2'd2;
	localparam logic [2:0] BIT_LAST = 3'd7;
	localparam logic [PAT_W-1:0] PAT_UNKNOWN = 8'hFF;

	// Head of the pattern queue as seen by the sequencer.
	typedef struct packed {
		logic             valid;
		logic [PAT_W-1:0] pattern;
	} head_t;

	// Segment pattern for one character; unknown codes and NUL give all ones.
	function automatic logic [PAT_W-1:0] seg_lookup(input logic [CHAR_W-1:0] ch);
		logic [PAT_W-1:0] pat;
		case (ch)
			8'h20: pat = 8'h00;
			8'h2E: pat = 8'h7F;
			8'h30: pat = 8'h84;
			8'h31: pat = 8'h9F;
			8'h32: pat = 8'hC8;
			8'h33: pat = 8'h8A;
			8'h34: pat = 8'h93;
			8'h35: pat = 8'hA2;
			8'h36: pat = 8'hA0;
			8'h37: pat = 8'h8F;
			8'h38: pat = 8'h80;
			8'h39: pat = 8'h82;
			8'h45: pat = 8'hE0;
			8'h46: pat = 8'hE1;
			8'h48: pat = 8'h91;
			8'h4C: pat = 8'hF4;
			8'h4F: pat = 8'h84;
			8'h50: pat = 8'hC1;
			8'h52: pat = 8'h81;
			8'h61: pat = 8'hFE;
			8'h62: pat = 8'hFD;
			8'h63: pat = 8'hFB;
			8'h64: pat = 8'hF7;
			8'h65: pat = 8'hEF;
			8'h66: pat = 8'hDF;
			8'h67: pat = 8'hBF;
			8'h7A: pat = 8'hEA;
			default: pat = PAT_UNKNOWN;
		endcase
		return pat;
	endfunction

endpackage

FILE: design/seven_segment_char_shifter.sv
// Top level of the seven-segment character shifter.
//
//   Channel  Direction  Beat contents
//   s_*      in         tdata[7:0] character
//   m_*      out        tdata[0] data_bit, tdata[1] clock_bit; tuser[1:0] kind; tlast last
//
// Each character yields 26 output beats, one per cycle while m_tready is high;
// the sequencer's output register sets that pace.
// Characters are looked up on entry and queued in a small memory, so up to
// QUEUE_DEPTH + 1 characters can wait while a run is going out.
// Reset is asynchronous and needs no clearing pass; the block is ready right after it.
// A stall on m_tready holds the current beat and fills the queue.
module seven_segment_char_shifter #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] character
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [0] data_bit, [1] clock_bit, [7:2] zero
	output logic [1:0] m_tuser,   // [1:0] kind
	output logic       m_tlast
);

	`include "seven_segment_char_shifter_assert.svh"

	sscs_pkg::head_t head;
	logic            take;
	logic            full;
	logic            stored;
	logic            wr_en;

	assign s_tready = !full;
	assign wr_en = s_tvalid && s_tready;

	// Pattern queue, written with the looked-up segment pattern.
	sscs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (sscs_pkg::seg_lookup(s_tdata)),
		.take    (take),
		.full    (full),
		.stored  (stored),
		.head    (head)
	);

	// Run sequencer and output register.
	sscs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.take     (take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// An accepted character sits in the memory in the cycle after it is accepted.
	`SSCS_ASSERT_NEXT(a_char_stored, wr_en, stored)
	// After an end beat goes out, the next beat is a begin or nothing.
	`SSCS_ASSERT_NEXT(a_begin_after_end, m_tvalid && m_tready && m_tlast,
		!m_tvalid || m_tuser == sscs_pkg::KIND_BEGIN)
	// The head is only taken when it holds a pattern.
	`SSCS_ASSERT_NOW(a_take_valid, take, head.valid)

endmodule

FILE: design/sscs_queue.sv
// Pattern queue: a synchronous memory with a registered read port feeding a head slot.
module sscs_queue #(
	parameter int DEPTH = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [sscs_pkg::PAT_W-1:0] wr_data,
	input  logic                      take,
	output logic                      full,
	output logic                      stored,
	output sscs_pkg::head_t           head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [sscs_pkg::PAT_W-1:0] mem [DEPTH];
	logic [sscs_pkg::PAT_W-1:0] rd_data_q;
	logic [AW-1:0]              wr_ptr_q;
	logic [AW-1:0]              rd_ptr_q;
	logic [AW:0]                level_q;
	logic                       head_valid_q;
	logic                       rd_issue;

	// Read the next entry whenever the head slot is empty or being taken.
	assign rd_issue = (level_q != '0) && (!head_valid_q || take);
	assign full = (level_q == (AW+1)'(DEPTH));
	assign stored = (level_q != '0);
	assign head.valid = head_valid_q;
	assign head.pattern = rd_data_q;

	// Memory array with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
		if (rd_issue) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	// Pointers, fill level and head valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
			head_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_issue) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			level_q <= level_q + (AW+1)'(wr_en) - (AW+1)'(rd_issue);
			if (rd_issue) begin
				head_valid_q <= 1'b1;
			end else if (take) begin
				head_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/sscs_seq.sv
// Run sequencer: turns one segment pattern into the 26 beats of a shift-out run.
module sscs_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sscs_pkg::head_t        head,
	output logic                   take,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [7:0]             m_tdata,
	output logic [1:0]             m_tuser,
	output logic                   m_tlast
);

	sscs_pkg::seq_state_t       state_q, state_d;
	logic [sscs_pkg::PAT_W-1:0] shift_q, shift_d;
	logic [2:0]                 bit_q, bit_d;
	logic [1:0]                 phase_q, phase_d;
	logic                       out_valid_q, out_valid_d;
	sscs_pkg::kind_t            kind_q, kind_d;
	logic                       data_q, data_d;
	logic                       clock_q, clock_d;
	logic                       last_q, last_d;
	logic                       adv;

	// The output register can take a new beat when empty or being drained.
	assign adv = !out_valid_q || m_tready;

	// Next state and the beat to place in the output register.
	always_comb begin
		state_d = state_q;
		shift_d = shift_q;
		bit_d = bit_q;
		phase_d = phase_q;
		out_valid_d = adv ? 1'b0 : out_valid_q;
		kind_d = kind_q;
		data_d = data_q;
		clock_d = clock_q;
		last_d = last_q;
		take = 1'b0;
		case (state_q)
			sscs_pkg::SEQ_IDLE: begin
				if (adv && head.valid) begin
					take = 1'b1;
					out_valid_d = 1'b1;
					kind_d = sscs_pkg::KIND_BEGIN;
					data_d = 1'b0;
					clock_d = 1'b0;
					last_d = 1'b0;
					shift_d = head.pattern;
					bit_d = '0;
					phase_d = '0;
					state_d = sscs_pkg::SEQ_FRAME;
				end
			end
			sscs_pkg::SEQ_FRAME: begin
				if (adv) begin
					out_valid_d = 1'b1;
					kind_d = sscs_pkg::KIND_PORT;
					data_d = shift_q[0];
					clock_d = (phase_q == sscs_pkg::PHASE_HIGH);
					last_d = 1'b0;
					if (phase_q == sscs_pkg::PHASE_LAST) begin
						phase_d = '0;
						shift_d = shift_q >> 1;
						bit_d = bit_q + 1'b1;
						if (bit_q == sscs_pkg::BIT_LAST) begin
							state_d = sscs_pkg::SEQ_END;
						end
					end else begin
						phase_d = phase_q + 1'b1;
					end
				end
			end
			sscs_pkg::SEQ_END: begin
				if (adv) begin
					out_valid_d = 1'b1;
					kind_d = sscs_pkg::KIND_END;
					data_d = 1'b0;
					clock_d = 1'b0;
					last_d = 1'b1;
					state_d = sscs_pkg::SEQ_IDLE;
				end
			end
			default: begin
				state_d = sscs_pkg::SEQ_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sscs_pkg::SEQ_IDLE;
			bit_q <= '0;
			phase_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			bit_q <= bit_d;
			phase_q <= phase_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Pattern shifter and output payload.
	always_ff @(posedge clk) begin
		shift_q <= shift_d;
		kind_q <= kind_d;
		data_q <= data_d;
		clock_q <= clock_d;
		last_q <= last_d;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'b0, clock_q, data_q};
	assign m_tuser = kind_q;
	assign m_tlast = last_q;

endmodule

FILE: sim/tb_seven_segment_char_shifter.sv
// Self-checking testbench for the seven-segment character shifter: random stalls and a scoreboard.
module tb_seven_segment_char_shifter;

	localparam int RANDOM_CHARS = 86;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 900000;
	localparam int HOLD_OFF_CYCLES = 500;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] character
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [0] data_bit, [1] clock_bit, [7:2] zero
	logic [1:0] m_tuser;   // [1:0] kind
	logic       m_tlast;

	// One output beat as the block should present it.
	typedef struct {
		sscs_pkg::kind_t kind;
		bit              data_bit;
		bit              clock_bit;
		bit              last;
	} seg_beat_t;

	// Expected beat store, fed per accepted character and drained per output beat.
	class seg_scoreboard;
		seg_beat_t expected_beats[$];
		int        errors;
		int        chars_noted;
		int        unknown_chars;
		int        beats_checked;

		// Segment pattern for a character; anything outside the table lights nothing.
		function logic [7:0] segment_pattern(logic [7:0] ch);
			logic [7:0] pat;
			case (ch)
				8'h20: pat = 8'h00;
				8'h2E: pat = 8'h7F;
				8'h30: pat = 8'h84;
				8'h31: pat = 8'h9F;
				8'h32: pat = 8'hC8;
				8'h33: pat = 8'h8A;
				8'h34: pat = 8'h93;
				8'h35: pat = 8'hA2;
				8'h36: pat = 8'hA0;
				8'h37: pat = 8'h8F;
				8'h38: pat = 8'h80;
				8'h39: pat = 8'h82;
				8'h45: pat = 8'hE0;
				8'h46: pat = 8'hE1;
				8'h48: pat = 8'h91;
				8'h4C: pat = 8'hF4;
				8'h4F: pat = 8'h84;
				8'h50: pat = 8'hC1;
				8'h52: pat = 8'h81;
				8'h61: pat = 8'hFE;
				8'h62: pat = 8'hFD;
				8'h63: pat = 8'hFB;
				8'h64: pat = 8'hF7;
				8'h65: pat = 8'hEF;
				8'h66: pat = 8'hDF;
				8'h67: pat = 8'hBF;
				8'h7A: pat = 8'hEA;
				default: pat = sscs_pkg::PAT_UNKNOWN;
			endcase
			return pat;
		endfunction

		function bit is_known(logic [7:0] ch);
			return ch != 8'h00 && segment_pattern(ch) != sscs_pkg::PAT_UNKNOWN;
		endfunction

		// An accepted character queues a begin beat, eight three-beat bit frames, and an end beat.
		function void note_char(logic [7:0] ch);
			logic [7:0] pat;
			seg_beat_t  bt;
			pat = segment_pattern(ch);
			chars_noted++;
			if (!is_known(ch)) begin
				unknown_chars++;
			end
			bt = '{kind: sscs_pkg::KIND_BEGIN, data_bit: 1'b0, clock_bit: 1'b0, last: 1'b0};
			expected_beats.push_back(bt);
			for (int b = 0; b < 8; b++) begin
				for (int p = 0; p <= sscs_pkg::PHASE_LAST; p++) begin
					bt = '{kind: sscs_pkg::KIND_PORT, data_bit: pat[b],
						clock_bit: (p == sscs_pkg::PHASE_HIGH), last: 1'b0};
					expected_beats.push_back(bt);
				end
			end
			bt = '{kind: sscs_pkg::KIND_END, data_bit: 1'b0, clock_bit: 1'b0, last: 1'b1};
			expected_beats.push_back(bt);
		endfunction

		// Compare one output beat with the oldest expectation, field by field.
		function void check_beat(logic [1:0] kind, logic data_bit, logic clock_bit, logic last,
				logic [5:0] pad);
			seg_beat_t bt;
			beats_checked++;
			if (expected_beats.size() == 0) begin
				$error("output beat with nothing expected: kind %0d data %0b clock %0b last %0b",
					kind, data_bit, clock_bit, last);
				errors++;
				return;
			end
			bt = expected_beats.pop_front();
			if (kind !== bt.kind) begin
				$error("kind: expected %0d, got %0d", bt.kind, kind);
				errors++;
			end
			if (data_bit !== bt.data_bit) begin
				$error("data_bit: expected %0b, got %0b", bt.data_bit, data_bit);
				errors++;
			end
			if (clock_bit !== bt.clock_bit) begin
				$error("clock_bit: expected %0b, got %0b", bt.clock_bit, clock_bit);
				errors++;
			end
			if (last !== bt.last) begin
				$error("last: expected %0b, got %0b", bt.last, last);
				errors++;
			end
			if (pad !== 6'd0) begin
				$error("tdata[7:2]: expected 0, got %0h", pad);
				errors++;
			end
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction
	endclass

	seg_scoreboard sb;
	bit            quiet;
	int            hold_off_left;
	int            cycle_count;

	seven_segment_char_shifter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Idle length: mostly short, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80) begin
			return $urandom_range(1, 3);
		end else if (roll < 95) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Offer one character after an optional gap and wait for the beat to be taken.
	task automatic send_char(input logic [7:0] ch);
		int gap;
		gap = 0;
		if (!quiet && hold_off_left == 0 && $urandom_range(0, 9) < 3) begin
			gap = pick_gap();
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		do @(posedge clk); while (!s_tready);
		sb.note_char(ch);
	endtask

	// Receiver: random stalls, plus one long hold-off that the sender can request.
	initial begin
		int gap_left;
		gap_left = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				m_tready <= 1'b0;
				hold_off_left--;
			end else if (gap_left > 0) begin
				m_tready <= 1'b0;
				gap_left--;
			end else if (!quiet && $urandom_range(0, 9) < 2) begin
				m_tready <= 1'b0;
				gap_left = pick_gap() - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Every accepted output beat goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_beat(m_tuser, m_tdata[0], m_tdata[1], m_tlast, m_tdata[7:2]);
		end
	end

	// Watchdog on the whole run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_seven_segment_char_shifter: done, errors");
		$finish;
	end

	// Main sequence: reset, directed characters, random characters, drain, report.
	initial begin
		logic [7:0] directed_chars [24];
		logic [7:0] ch;
		sb = new();
		quiet = 1'b0;
		hold_off_left = 0;
		// NUL, the top code, both sides of the upper-half boundary, table entries and a few misses.
		directed_chars = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'h20, 8'h2E, 8'h30,
			8'h31, 8'h38, 8'h39, 8'h45, 8'h4C, 8'h52, 8'h61, 8'h67,
			8'h7A, 8'h41, 8'h5A, 8'h4F, 8'h4F, 8'h20, 8'hAA, 8'h55};
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_chars[i]) begin
			send_char(directed_chars[i]);
		end

		// Mostly displayable characters, the rest any byte at all.
		for (int n = 0; n < RANDOM_CHARS; n++) begin
			quiet = (n >= 40 && n < 60);
			if (n == 70) begin
				hold_off_left = HOLD_OFF_CYCLES;
			end
			if ($urandom_range(0, 9) < 7) begin
				do ch = 8'($urandom_range(0, 127)); while (!sb.is_known(ch));
			end else begin
				ch = 8'($urandom_range(0, 255));
			end
			send_char(ch);
		end
		s_tvalid <= 1'b0;
		quiet = 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.pending() != 0) begin
			$error("%0d expected beats never arrived", sb.pending());
			sb.errors++;
		end
		$display("Sent %0d characters, %0d of them outside the table or NUL.",
			sb.chars_noted, sb.unknown_chars);
		$display("Checked %0d output beats under random stalls and one long hold-off.",
			sb.beats_checked);
		if (sb.errors == 0) begin
			$display("tb_seven_segment_char_shifter: done, clean");
		end else begin
			$display("tb_seven_segment_char_shifter: done, errors");
		end
		$finish;
	end

endmodule
